>>> design/downscale_threshold_preview_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the downscale/threshold preview core
// Shared concurrent-check shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DOWNSCALE_THRESHOLD_PREVIEW_CORE_DEFINES_SVH
`define DOWNSCALE_THRESHOLD_PREVIEW_CORE_DEFINES_SVH

// Same-cycle implication
`define DTP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/dtp_pkg.sv
// ----------------------------------------------------------------------------
// dtp_pkg
// Constants and types for the downscale/threshold preview core.
// ----------------------------------------------------------------------------
`default_nettype none

package dtp_pkg;

  // Destination frame size (powers of two: divisions become bit selects)
  localparam int DEST_WIDTH  = 128;
  localparam int DEST_HEIGHT = 64;

  localparam int DX_W      = $clog2(DEST_WIDTH);   // dest_x width
  localparam int DY_W      = $clog2(DEST_HEIGHT);  // dest_y width
  localparam int SRC_W     = 12;                   // source size / position width
  localparam int PIX_W     = 8;
  localparam int COL_ACC_W = SRC_W + DX_W;         // holds dest column * width
  localparam int ROW_ACC_W = SRC_W + DY_W;         // holds dest row * height
  localparam int OUT_DATA_W = 16;                  // x, y, white padded to bytes

  // Reset values of the configuration registers
  localparam logic [SRC_W-1:0] SRC_WIDTH_RST  = 12'd160;
  localparam logic [SRC_W-1:0] SRC_HEIGHT_RST = 12'd120;
  localparam logic [PIX_W-1:0] THRESHOLD_RST  = 8'd128;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_THRESHOLD  = 2'd2
  } cfg_reg_t;

  // One destination pixel
  typedef struct packed {
    logic            last;
    logic            white;
    logic [DY_W-1:0] y;
    logic [DX_W-1:0] x;
  } res_t;

endpackage

`default_nettype wire

>>> design/downscale_threshold_preview_core.sv
// A kept pixel goes to the output register, or to the skid entry on a stall.
// Throughput: one source pixel per cycle while the skid entry is empty; position
//   tracking and the keep decision finish in the accept cycle, and an output
//   register plus one skid entry keep s_tready independent of m_tready.
// Reset (rst, synchronous): position and destination counters clear, the
//   size/threshold registers return to 160, 120 and 128, output queue empties.
// ----------------------------------------------------------------------------
// downscale_threshold_preview_core
// Nearest-neighbour downscale of a grayscale raster stream to 128x64 with a
// binary threshold. Running accumulators track dest_index * source_size.
// ----------------------------------------------------------------------------
`default_nettype none

`include "downscale_threshold_preview_core_defines.svh"

module downscale_threshold_preview_core
  import dtp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [SRC_W-1:0]      cfg_data,
  // source pixel stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel
  input  wire logic [0:0]            s_tuser,   // [0] frame_start
  // destination pixel stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // [6:0] dest_x, [12:7] dest_y,
                                                // [13] white, [15:14] zero
  output logic                       m_tlast    // frame_done
);

  // Configuration registers
  logic [SRC_W-1:0] src_width;
  logic [SRC_W-1:0] src_height;
  logic [PIX_W-1:0] threshold;

  // Position state
  logic [SRC_W-1:0]     col, col_next;
  logic [SRC_W-1:0]     row, row_next;
  logic [DX_W-1:0]      dcol, dcol_next;
  logic [DY_W-1:0]      drow, drow_next;
  logic [COL_ACC_W-1:0] col_acc, col_acc_next;
  logic [ROW_ACC_W-1:0] row_acc, row_acc_next;

  // Output register and skid entry
  logic out_valid;
  res_t out_res;
  logic skid_valid;
  res_t skid_res;

  // Working values
  logic                 accept;
  logic                 start;
  logic [SRC_W-1:0]     eff_w;
  logic [SRC_W-1:0]     eff_h;
  logic [SRC_W-1:0]     cur_col;
  logic [SRC_W-1:0]     cur_row;
  logic [DX_W-1:0]      cur_dcol;
  logic [DY_W-1:0]      cur_drow;
  logic [COL_ACC_W-1:0] cur_col_acc;
  logic [ROW_ACC_W-1:0] cur_row_acc;
  logic                 col_hit;
  logic                 row_hit;
  logic                 keep;
  res_t                 new_res;
  logic                 pop;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign accept    = s_tvalid && s_tready;
  assign pop       = out_valid && m_tready;
  assign start     = s_tuser[0];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SRC_WIDTH_RST;
      src_height <= SRC_HEIGHT_RST;
      threshold  <= THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_SRC_WIDTH:  src_width  <= cfg_data;
        REG_SRC_HEIGHT: src_height <= cfg_data;
        REG_THRESHOLD:  threshold  <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective source size: never below the destination size
  assign eff_w = (src_width  < SRC_W'(DEST_WIDTH))  ? SRC_W'(DEST_WIDTH)  : src_width;
  assign eff_h = (src_height < SRC_W'(DEST_HEIGHT)) ? SRC_W'(DEST_HEIGHT) : src_height;

  // Frame start realigns everything to zero before the pixel is taken
  assign cur_col     = start ? '0 : col;
  assign cur_row     = start ? '0 : row;
  assign cur_dcol    = start ? '0 : dcol;
  assign cur_drow    = start ? '0 : drow;
  assign cur_col_acc = start ? '0 : col_acc;
  assign cur_row_acc = start ? '0 : row_acc;

  // floor(acc / DEST) == position, DEST being a power of two
  assign col_hit = (cur_col_acc[COL_ACC_W-1:DX_W] == cur_col);
  assign row_hit = (cur_row_acc[ROW_ACC_W-1:DY_W] == cur_row);
  assign keep    = col_hit && row_hit;

  // Result of this pixel
  always_comb begin
    new_res.x     = cur_dcol;
    new_res.y     = cur_drow;
    new_res.white = (s_tdata > threshold);
    new_res.last  = (cur_dcol == DX_W'(DEST_WIDTH - 1)) &&
                    (cur_drow == DY_W'(DEST_HEIGHT - 1));
  end

  // Position update
  always_comb begin
    col_next     = cur_col;
    row_next     = cur_row;
    dcol_next    = cur_dcol;
    drow_next    = cur_drow;
    col_acc_next = cur_col_acc;
    row_acc_next = cur_row_acc;

    // advance destination column on a kept pixel, hold at the last one
    if (keep && (cur_dcol < DX_W'(DEST_WIDTH - 1))) begin
      dcol_next    = cur_dcol + 1'b1;
      col_acc_next = cur_col_acc + COL_ACC_W'(eff_w);
    end

    if (cur_col >= eff_w - 1'b1) begin
      // end of source line
      col_next     = '0;
      dcol_next    = '0;
      col_acc_next = '0;
      if (row_hit && (cur_drow < DY_W'(DEST_HEIGHT - 1))) begin
        drow_next    = cur_drow + 1'b1;
        row_acc_next = cur_row_acc + ROW_ACC_W'(eff_h);
      end
      if (cur_row >= eff_h - 1'b1) begin
        // end of source frame: wrap as for a new frame
        row_next     = '0;
        drow_next    = '0;
        row_acc_next = '0;
      end else begin
        row_next = cur_row + 1'b1;
      end
    end else begin
      col_next = cur_col + 1'b1;
    end
  end

  // Position registers
  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      dcol    <= '0;
      drow    <= '0;
      col_acc <= '0;
      row_acc <= '0;
    end else if (accept) begin
      col     <= col_next;
      row     <= row_next;
      dcol    <= dcol_next;
      drow    <= drow_next;
      col_acc <= col_acc_next;
      row_acc <= row_acc_next;
    end
  end

  // Output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || pop) begin
      out_valid <= accept && keep;
    end else if (accept && keep) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_res <= skid_res;
      end
    end else if (!out_valid || pop) begin
      out_res <= new_res;
    end else begin
      skid_res <= new_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_res.white, out_res.y, out_res.x};
  assign m_tlast  = out_res.last;

  // Checks
  `DTP_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid,
    "skid entry held while output register empty")
  `DTP_ASSERT_NOW(a_last_at_corner, m_tvalid && m_tlast,
    (m_tdata[DX_W-1:0] == DX_W'(DEST_WIDTH - 1)) &&
    (m_tdata[DX_W+DY_W-1:DX_W] == DY_W'(DEST_HEIGHT - 1)),
    "frame_done away from the last destination pixel")
  `DTP_ASSERT_NOW(a_col_acc_zero, dcol == '0, col_acc == '0,
    "column accumulator nonzero at destination column zero")
  `DTP_ASSERT_NOW(a_row_acc_zero, drow == '0, row_acc == '0,
    "row accumulator nonzero at destination row zero")
  `DTP_ASSERT_NEXT(a_stall_to_skid, out_valid && !m_tready && !skid_valid && accept && keep,
    skid_valid, "kept pixel lost while output stalled")

endmodule

`default_nettype wire
